// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Concurrent assertion that is checked at every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== design/tlc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlc_pkg
// Types and constants of the tool lock controller: mode codes, host
// command codes and the layouts of the input and result beats.
// ----------------------------------------------------------------------------
package tlc_pkg;

    // Lock controller mode
    typedef enum logic [1:0] {
        MODE_IDLE      = 2'd0,
        MODE_ATTACHED  = 2'd1,
        MODE_UNLOCKING = 2'd2
    } tlc_mode_t;

    // Host command codes
    localparam logic [7:0] OP_UNLOCK   = 8'd0;
    localparam logic [7:0] OP_LOCK     = 8'd1;
    localparam logic [7:0] OP_RAIL_ON  = 8'd2;
    localparam logic [7:0] OP_RAIL_OFF = 8'd3;

    // Unlock timeout after reset, in ms
    localparam logic [31:0] TIMEOUT_RESET_MS = 32'd5000;

    // Input beat payload, lowest field last
    typedef struct packed {
        logic [5:0]  pad;
        logic [31:0] now_ms;
        logic [15:0] sensed_tool_id;
        logic        tool_detected;
        logic        button_unlock;
        logic [7:0]  op;
    } tlc_in_t;

    // Result beat payload, lowest field last
    typedef struct packed {
        logic        pad;
        logic        detect_enable;
        logic        servo_locked;
        logic        rail_7v8;
        logic        rail_5v;
        logic [15:0] tool_id;
        logic        warning_flag;
        tlc_mode_t   mode_code;
    } tlc_out_t;

endpackage

// ===== design/tool_lock_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tool_lock_controller
// Lock controller of a tool changer, advanced once per control tick beat.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one control tick per beat: the optional host
//   command (tuser marks it valid), the unlock button, the tool sense, the
//   sensed tool id and the millisecond time. The master stream returns one
//   result beat per tick with the mode, the sticky warning, the cached tool
//   id and the rail, servo and detection enables after that tick.
//   cfg_wr_en/cfg_wr_data write the unlock timeout in ms; write it only
//   while no tick is in flight.
// Timing:
//   Two register stages: an input register and the state/result register.
//   Ticks pass the input register, then the state/result register; one tick
//   is taken every cycle unless the master stream stalls. State update: one
//   pass of compare-and-set logic, one 32-bit subtract/compare for timeout.
// Reset and stall:
//   Reset empties both stages, sets the timeout to 5000 ms, the mode to
//   idle and the servo to locked. While the master stream stalls, the
//   result beat holds; one more tick is taken into the input register and
//   tready then drops until the result is taken.
// ----------------------------------------------------------------------------
module tool_lock_controller
    import tlc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Tick input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // op[7:0], button_unlock[8], tool_detected[9], sensed_tool_id[25:10],
    // now_ms[57:26], zero fill[63:58]
    input  logic [63:0] s_axis_tdata,
    // cmd_valid[0]
    input  logic        s_axis_tuser,
    // Result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // mode_code[1:0], warning_flag[2], tool_id[18:3], rail_5v[19],
    // rail_7v8[20], servo_locked[21], detect_enable[22], zero fill[23]
    output logic [23:0] m_axis_tdata,
    // Unlock timeout register
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data
);

    typedef struct packed {
        tlc_mode_t   mode;
        logic        awaiting_tool;
        logic        expect_insertion;
        logic [31:0] unlock_start;
        logic        warning_sticky;
        logic [15:0] cached_id;
        logic        power_5v;
        logic        power_7v8;
        logic        servo_lock;
        logic        detect_on;
    } tlc_state_t;

    // Begin an unlock wait from idle or attached
    function automatic tlc_state_t start_unlock(tlc_state_t s, logic [31:0] now);
        tlc_state_t r;
        r = s;
        if (!s.awaiting_tool && (s.mode == MODE_IDLE || s.mode == MODE_ATTACHED))
        begin
            r.expect_insertion = (s.mode == MODE_IDLE);
            r.power_7v8        = 1'b0;
            r.power_5v         = 1'b1;
            r.servo_lock       = 1'b0;
            r.detect_on        = 1'b1;
            r.awaiting_tool    = 1'b1;
            r.unlock_start     = now;
            r.mode             = MODE_UNLOCKING;
        end
        return r;
    endfunction

    logic        in_valid_reg;
    logic        in_valid_next;
    logic        in_cmd_reg;
    tlc_in_t     in_data_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        advance;
    logic        load_in;
    logic [31:0] timeout_reg;
    logic [31:0] elapsed;
    tlc_state_t  state_reg;
    tlc_state_t  state_next;
    tlc_out_t    result;

    // Pipeline flow control
    assign advance        = !out_valid_reg || m_axis_tready;
    assign s_axis_tready  = !in_valid_reg || advance;
    assign load_in        = s_axis_tvalid && s_axis_tready;
    assign in_valid_next  = s_axis_tready ? s_axis_tvalid : in_valid_reg;
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    // Hold the tick beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            in_cmd_reg  <= s_axis_tuser;
            in_data_reg <= tlc_in_t'(s_axis_tdata);
        end
    end

    // Take timeout writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET_MS;
        end
        else if (cfg_wr_en)
        begin
            timeout_reg <= cfg_wr_data;
        end
    end

    // Apply one tick: button, host command, wait resolution, tool loss
    always_comb
    begin
        state_next = state_reg;

        if (in_data_reg.button_unlock)
        begin
            state_next = start_unlock(state_next, in_data_reg.now_ms);
        end

        if (in_cmd_reg)
        begin
            case (in_data_reg.op)
                OP_UNLOCK:
                begin
                    state_next = start_unlock(state_next, in_data_reg.now_ms);
                end
                OP_LOCK:
                begin
                    state_next.servo_lock    = 1'b1;
                    state_next.awaiting_tool = 1'b0;
                    state_next.detect_on     = 1'b0;
                    if (in_data_reg.tool_detected)
                    begin
                        state_next.power_5v  = 1'b1;
                        state_next.power_7v8 = 1'b1;
                        state_next.mode      = MODE_ATTACHED;
                    end
                    else
                    begin
                        state_next.power_5v       = 1'b0;
                        state_next.power_7v8      = 1'b0;
                        state_next.mode           = MODE_IDLE;
                        state_next.warning_sticky = 1'b1;
                    end
                end
                OP_RAIL_ON:
                begin
                    state_next.power_7v8 = 1'b1;
                end
                OP_RAIL_OFF:
                begin
                    state_next.power_7v8 = 1'b0;
                end
                default:
                begin
                    state_next.power_7v8 = state_next.power_7v8;
                end
            endcase
        end

        // Measure the wait from a start that may have been set this tick
        elapsed = in_data_reg.now_ms - state_next.unlock_start;

        // Resolve a pending unlock wait
        if (state_next.awaiting_tool)
        begin
            if (state_next.expect_insertion && in_data_reg.tool_detected)
            begin
                state_next.cached_id      = in_data_reg.sensed_tool_id;
                state_next.servo_lock     = 1'b1;
                state_next.power_7v8      = 1'b1;
                state_next.power_5v       = 1'b0;
                state_next.awaiting_tool  = 1'b0;
                state_next.detect_on      = 1'b0;
                state_next.mode           = MODE_ATTACHED;
            end
            else if (!state_next.expect_insertion && !in_data_reg.tool_detected)
            begin
                state_next.cached_id      = 16'd0;
                state_next.servo_lock     = 1'b1;
                state_next.power_5v       = 1'b0;
                state_next.power_7v8      = 1'b0;
                state_next.awaiting_tool  = 1'b0;
                state_next.detect_on      = 1'b0;
                state_next.mode           = MODE_IDLE;
                state_next.warning_sticky = 1'b0;
            end
            else if (elapsed >= timeout_reg)
            begin
                // Relock; the timeout warning outlives the entry to idle
                state_next.servo_lock = 1'b1;
                state_next.power_5v   = 1'b0;
                if (state_next.expect_insertion)
                begin
                    state_next.power_7v8 = 1'b0;
                    state_next.mode      = MODE_IDLE;
                end
                else
                begin
                    state_next.power_7v8 = 1'b1;
                    state_next.mode      = MODE_ATTACHED;
                end
                state_next.warning_sticky = 1'b1;
                state_next.awaiting_tool  = 1'b0;
                state_next.detect_on      = 1'b0;
            end
        end

        // Drop to idle when the attached tool goes missing
        if (state_next.mode == MODE_ATTACHED && !in_data_reg.tool_detected &&
            !state_next.awaiting_tool)
        begin
            state_next.cached_id      = 16'd0;
            state_next.power_5v       = 1'b0;
            state_next.power_7v8      = 1'b0;
            state_next.servo_lock     = 1'b1;
            state_next.mode           = MODE_IDLE;
            state_next.warning_sticky = 1'b1;
        end
    end

    // Advance the state, which doubles as the result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg              <= 1'b0;
            state_reg.mode             <= MODE_IDLE;
            state_reg.awaiting_tool    <= 1'b0;
            state_reg.expect_insertion <= 1'b1;
            state_reg.unlock_start     <= 32'd0;
            state_reg.warning_sticky   <= 1'b0;
            state_reg.cached_id        <= 16'd0;
            state_reg.power_5v         <= 1'b0;
            state_reg.power_7v8        <= 1'b0;
            state_reg.servo_lock       <= 1'b1;
            state_reg.detect_on        <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance && in_valid_reg)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Pack the result beat
    always_comb
    begin
        result.pad           = 1'b0;
        result.detect_enable = state_reg.detect_on;
        result.servo_locked  = state_reg.servo_lock;
        result.rail_7v8      = state_reg.power_7v8;
        result.rail_5v       = state_reg.power_5v;
        result.tool_id       = state_reg.cached_id;
        result.warning_flag  = state_reg.warning_sticky;
        result.mode_code     = state_reg.mode;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = result;

endmodule

// ===== design/tlc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlc_checker
// Port-level checks of the tool lock controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tlc_checker
    import tlc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    tlc_out_t res;

    assign res = tlc_out_t'(m_axis_tdata);

    // No result beat in the cycle after reset is seen at an edge
    `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !m_axis_tvalid, "result beat during reset")

    // A stalled result beat holds its payload
    `ASSERT_RST(a_stall_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

    // With the output side empty, a tick is always taken
    `ASSERT_RST(a_ready_when_empty, clk, rst_n, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output")

    // Unlocking means servo open, detection on and 5 V rail up
    `ASSERT_RST(a_unlock_outputs, clk, rst_n, m_axis_tvalid && res.mode_code == MODE_UNLOCKING |-> !res.servo_locked && res.detect_enable && res.rail_5v, "unlocking outputs wrong")

    // Outside unlocking the servo is locked and detection is off
    `ASSERT_RST(a_locked_outputs, clk, rst_n, m_axis_tvalid && res.mode_code != MODE_UNLOCKING |-> res.servo_locked && !res.detect_enable, "locked outputs wrong")

endmodule

bind tool_lock_controller tlc_checker u_tlc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
